// ===== sv/ptsched_pkg.sv =====
`default_nettype none

package ptsched_pkg;

  localparam int DefMaxTasks = 8;
  localparam int PriW        = 8;
  localparam int TickW       = 32;
  localparam int DelayW      = 32;
  localparam int RunW        = 3;

  typedef enum logic [1:0] {
    REQ_CREATE   = 2'd0,
    REQ_DELAY    = 2'd1,
    REQ_TICK     = 2'd2,
    REQ_SCHEDULE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_BAD_PRI = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SL_READY   = 2'd0,
    SL_RUNNING = 2'd1,
    SL_BLOCKED = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_SWEEP,
    FS_COMMIT,
    FS_DONE
  } fsm_e;

  typedef struct packed {
    logic [PriW-1:0]  pri;
    slot_e            st;
    logic [TickW-1:0] wake;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/ptsched_if.sv =====
`default_nettype none

interface ptsched_req_if;
  import ptsched_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [PriW-1:0]   task_priority;
  logic [DelayW-1:0] delay_ticks;

  modport source (output valid, req_type, task_priority, delay_ticks, input ready);
  modport sink (input valid, req_type, task_priority, delay_ticks, output ready);
endinterface

interface ptsched_rsp_if;
  import ptsched_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [RunW-1:0]  running_task;
  logic [TickW-1:0] tick_now;

  modport source (output valid, status, running_task, tick_now, input ready);
  modport sink (input valid, status, running_task, tick_now, output ready);
endinterface

`default_nettype wire

// ===== sv/ptsched_ram.sv =====
`default_nettype none

module ptsched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/priority_task_scheduler_with_delays_unit.sv =====
// Fixed-priority task scheduler with timed delays.
// Requests arrive on req_i (valid/ready); each request gives exactly one item
// on rsp_o with the status, the slot now running and the tick counter.
// The task table (priority, state and wake tick per slot) lives in one
// synchronous RAM with a registered read. Create, and any request that has no
// table sweep to do (a delay while the idle task runs, or a tick or schedule
// with only the idle task present), goes from acceptance straight to the
// done state, which hands the result to the output register. Tick, schedule
// and delay otherwise sweep the created slots 1 to N-1 with one read and one
// write-back per cycle, N being the number of slots in use with the idle slot
// counted, at most MAX_TASKS, then commit the chosen task before the done state.
// Requests are taken one at a time, but a new request is accepted while the
// previous result still waits in the output register; a finished request
// holds until that register is free, so a stalled receiver stalls the block
// without loss.
// Reset empties the table to the idle task only, clears the tick counter and
// runs the idle task; the RAM needs no clearing since only created slots are
// ever read.
`default_nettype none

module priority_task_scheduler_with_delays_unit
  import ptsched_pkg::*;
#(
  parameter int MAX_TASKS = DefMaxTasks
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ptsched_req_if.sink    req_i,
  ptsched_rsp_if.source  rsp_o
);

  localparam int IW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int EW = $bits(entry_t);

  fsm_e              state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     running_q, running_d;
  logic [TickW-1:0]  tick_q, tick_d;
  req_e              req_q, req_d;
  logic [DelayW-1:0] dly_q, dly_d;
  status_e           status_q, status_d;
  logic [CW-1:0]     rd_idx_q, rd_idx_d;
  logic              pv_q, pv_d;
  logic [IW-1:0]     pv_idx_q, pv_idx_d;
  logic              found_q, found_d;
  logic [PriW-1:0]   best_pri_q, best_pri_d;
  logic [IW-1:0]     best_idx_q, best_idx_d;
  entry_t            best_ent_q, best_ent_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [RunW-1:0]   out_run_q, out_run_d;
  logic [TickW-1:0]  out_tick_q, out_tick_d;

  logic          ram_we, ram_re;
  logic [IW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_ent, new_ent;
  logic [TickW-1:0] wake_diff;
  logic          issue, cand;

  ptsched_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (EW'(ram_wdata)),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FS_IDLE;
      count_q     <= CW'(1);
      running_q   <= '0;
      tick_q      <= '0;
      rd_idx_q    <= '0;
      pv_q        <= 1'b0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      running_q   <= running_d;
      tick_q      <= tick_d;
      rd_idx_q    <= rd_idx_d;
      pv_q        <= pv_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    dly_q        <= dly_d;
    status_q     <= status_d;
    pv_idx_q     <= pv_idx_d;
    best_pri_q   <= best_pri_d;
    best_idx_q   <= best_idx_d;
    best_ent_q   <= best_ent_d;
    out_status_q <= out_status_d;
    out_run_q    <= out_run_d;
    out_tick_q   <= out_tick_d;
  end

  always_comb begin
    rd_ent    = entry_t'(ram_rdata);
    wake_diff = tick_q - rd_ent.wake;
    new_ent   = rd_ent;
    if (req_q == REQ_DELAY && pv_idx_q == running_q) begin
      new_ent.st   = SL_BLOCKED;
      new_ent.wake = tick_q + dly_q;
    end else if (rd_ent.st == SL_RUNNING) begin
      new_ent.st = SL_READY;
    end else if (req_q == REQ_TICK && rd_ent.st == SL_BLOCKED && rd_ent.wake != '0 &&
                 !wake_diff[TickW-1]) begin
      new_ent.st   = SL_READY;
      new_ent.wake = '0;
    end
    cand  = (new_ent.st == SL_READY) && (!found_q || new_ent.pri < best_pri_q);
    issue = rd_idx_q < count_q;
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    running_d    = running_q;
    tick_d       = tick_q;
    req_d        = req_q;
    dly_d        = dly_q;
    status_d     = status_q;
    rd_idx_d     = rd_idx_q;
    pv_d         = pv_q;
    pv_idx_d     = pv_idx_q;
    found_d      = found_q;
    best_pri_d   = best_pri_q;
    best_idx_d   = best_idx_q;
    best_ent_d   = best_ent_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_run_d    = out_run_q;
    out_tick_d   = out_tick_q;
    ram_we       = 1'b0;
    ram_waddr    = pv_idx_q;
    ram_wdata    = new_ent;
    ram_re       = 1'b0;
    ram_raddr    = rd_idx_q[IW-1:0];
    req_i.ready  = 1'b0;

    unique case (state_q)
      FS_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          req_d    = req_e'(req_i.req_type);
          dly_d    = req_i.delay_ticks;
          status_d = STAT_OK;
          rd_idx_d = CW'(1);
          pv_d     = 1'b0;
          found_d  = 1'b0;
          state_d  = FS_DONE;
          unique case (req_e'(req_i.req_type))
            REQ_CREATE: begin
              if (count_q >= CW'(MAX_TASKS)) begin
                status_d = STAT_FULL;
              end else if (req_i.task_priority == '0) begin
                status_d = STAT_BAD_PRI;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[IW-1:0];
                ram_wdata = '{pri: req_i.task_priority, st: SL_READY, wake: '0};
                count_d   = count_q + CW'(1);
              end
            end
            REQ_DELAY: begin
              if (running_q != '0) begin
                state_d = FS_SWEEP;
              end
            end
            REQ_TICK: begin
              tick_d = tick_q + TickW'(1);
              if (count_q > CW'(1)) begin
                state_d = FS_SWEEP;
              end
            end
            REQ_SCHEDULE: begin
              if (count_q > CW'(1)) begin
                state_d = FS_SWEEP;
              end
            end
            default: ;
          endcase
        end
      end
      FS_SWEEP: begin
        if (issue) begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + CW'(1);
        end
        pv_d     = issue;
        pv_idx_d = rd_idx_q[IW-1:0];
        if (pv_q) begin
          ram_we = 1'b1;
          if (cand) begin
            found_d    = 1'b1;
            best_pri_d = new_ent.pri;
            best_idx_d = pv_idx_q;
            best_ent_d = new_ent;
          end
        end
        if (!issue && !pv_q) begin
          state_d = FS_COMMIT;
        end
      end
      FS_COMMIT: begin
        if (found_q) begin
          ram_we       = 1'b1;
          ram_waddr    = best_idx_q;
          ram_wdata    = best_ent_q;
          ram_wdata.st = SL_RUNNING;
          running_d    = best_idx_q;
        end else begin
          running_d = '0;
        end
        found_d = 1'b0;
        state_d = FS_DONE;
      end
      FS_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_run_d    = RunW'(running_q);
          out_tick_d   = tick_q;
          state_d      = FS_IDLE;
        end
      end
      default: state_d = FS_IDLE;
    endcase
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.running_task = out_run_q;
  assign rsp_o.tick_now     = out_tick_q;

`ifndef SYNTHESIS
  a_running_created: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(running_q) < count_q)
    else $error("Running slot lies beyond the created tasks.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q >= CW'(1) && count_q <= CW'(MAX_TASKS))
    else $error("Task count out of range.");

  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready && req_i.req_type == REQ_TICK |=>
    tick_q == $past(tick_q) + TickW'(1))
    else $error("Tick request did not advance the counter by one.");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("Table write and read hit the same slot in one cycle.");

  a_best_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> best_idx_q != '0)
    else $error("Idle slot chosen as a ready candidate.");
`endif

endmodule

`default_nettype wire

// ===== tb/priority_task_scheduler_with_delays_unit_tb.sv =====
`timescale 1ns / 100ps

module priority_task_scheduler_with_delays_unit_tb;
  import ptsched_pkg::*;

  localparam int NumSlots = DefMaxTasks;
  localparam int RandomRequests = 1525;

  typedef struct packed {
    status_e          status;
    logic [RunW-1:0]  running;
    logic [TickW-1:0] tick;
  } sched_outcome_t;

  typedef struct {
    req_e              kind;
    logic [PriW-1:0]   pri;
    logic [DelayW-1:0] dly;
    bit                typed;
    sched_outcome_t    outcome;
  } request_row_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ptsched_req_if req_if ();
  ptsched_rsp_if rsp_if ();

  priority_task_scheduler_with_delays_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  int               slots_used;
  int               run_slot;
  logic [TickW-1:0] tick_cnt;
  logic [PriW-1:0]  slot_pri [NumSlots];
  slot_e            slot_st [NumSlots];
  logic [TickW-1:0] slot_wake [NumSlots];

  sched_outcome_t pending_outcomes [$];
  sched_outcome_t oldest_outcome;
  int             fail_count = 0;
  int             burst_left = 0;
  rx_mode_e       rx_mode = RX_OPEN;
  int             rx_left = 0;

  request_row_t directed_rows [24];

  function automatic void clear_table();
    slots_used = 1;
    run_slot = 0;
    tick_cnt = '0;
    for (int i = 0; i < NumSlots; i++) begin
      slot_pri[i] = '0;
      slot_st[i] = SL_READY;
      slot_wake[i] = '0;
    end
  endfunction

  function automatic void pick_runner();
    bit              found;
    logic [PriW-1:0] best_pri;
    int              best;
    found = 1'b0;
    best_pri = '0;
    best = 0;
    if (slot_st[run_slot] == SL_RUNNING) slot_st[run_slot] = SL_READY;
    if (slots_used <= 1) return;
    for (int i = 1; i < slots_used; i++) begin
      if (slot_st[i] == SL_READY && (!found || slot_pri[i] < best_pri)) begin
        found = 1'b1;
        best_pri = slot_pri[i];
        best = i;
      end
    end
    run_slot = best;
    slot_st[best] = SL_RUNNING;
  endfunction

  function automatic sched_outcome_t advance_table(req_e kind, logic [PriW-1:0] pri,
                                                   logic [DelayW-1:0] dly);
    sched_outcome_t   res;
    logic [TickW-1:0] diff;
    res.status = STAT_OK;
    case (kind)
      REQ_CREATE: begin
        if (slots_used >= NumSlots) begin
          res.status = STAT_FULL;
        end else if (pri == '0) begin
          res.status = STAT_BAD_PRI;
        end else begin
          slot_pri[slots_used] = pri;
          slot_st[slots_used] = SL_READY;
          slot_wake[slots_used] = '0;
          slots_used++;
        end
      end
      REQ_DELAY: begin
        if (run_slot != 0) begin
          slot_wake[run_slot] = tick_cnt + dly;
          slot_st[run_slot] = SL_BLOCKED;
          pick_runner();
        end
      end
      REQ_TICK: begin
        tick_cnt = tick_cnt + 1'b1;
        for (int i = 1; i < slots_used; i++) begin
          diff = tick_cnt - slot_wake[i];
          if (slot_st[i] == SL_BLOCKED && slot_wake[i] != '0 && !diff[TickW-1]) begin
            slot_st[i] = SL_READY;
            slot_wake[i] = '0;
          end
        end
        pick_runner();
      end
      default: begin
        pick_runner();
      end
    endcase
    res.running = RunW'(run_slot);
    res.tick = tick_cnt;
    return res;
  endfunction

  task automatic drive_request(input req_e kind, input logic [PriW-1:0] pri,
                               input logic [DelayW-1:0] dly, input bit typed,
                               input sched_outcome_t typed_outcome);
    sched_outcome_t predicted;
    int             gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.task_priority <= pri;
    req_if.delay_ticks <= dly;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = advance_table(kind, pri, dly);
    pending_outcomes.push_back(typed ? typed_outcome : predicted);
  endtask

  task automatic drain_outcomes();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 2));
      rx_left = $urandom_range(4, 40);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   rsp_if.ready <= 1'b1;
      RX_RANDOM: rsp_if.ready <= $urandom_range(0, 1) == 1;
      default:   rsp_if.ready <= $urandom_range(0, 7) == 0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("Result item arrived with nothing expected.");
        fail_count++;
      end else begin
        oldest_outcome = pending_outcomes.pop_front();
        if (rsp_if.status !== oldest_outcome.status) begin
          $error("status: expected %0d, got %0d", oldest_outcome.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.running_task !== oldest_outcome.running) begin
          $error("running_task: expected %0d, got %0d", oldest_outcome.running,
                 rsp_if.running_task);
          fail_count++;
        end
        if (rsp_if.tick_now !== oldest_outcome.tick) begin
          $error("tick_now: expected %0h, got %0h", oldest_outcome.tick, rsp_if.tick_now);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    req_e              kind;
    logic [PriW-1:0]   pri;
    logic [DelayW-1:0] dly;
    int                pick;
    req_if.valid = 1'b0;
    req_if.req_type = REQ_CREATE;
    req_if.task_priority = '0;
    req_if.delay_ticks = '0;
    rsp_if.ready = 1'b0;
    clear_table();
    directed_rows = '{
      '{REQ_SCHEDULE, 8'd0,   32'd0,          1'b1, '{STAT_OK,      3'd0, 32'd0}},
      '{REQ_DELAY,    8'd0,   32'd5,          1'b1, '{STAT_OK,      3'd0, 32'd0}},
      '{REQ_TICK,     8'd0,   32'd0,          1'b1, '{STAT_OK,      3'd0, 32'd1}},
      '{REQ_CREATE,   8'd0,   32'd0,          1'b1, '{STAT_BAD_PRI, 3'd0, 32'd1}},
      '{REQ_CREATE,   8'd255, 32'd0,          1'b1, '{STAT_OK,      3'd0, 32'd1}},
      '{REQ_SCHEDULE, 8'd0,   32'd0,          1'b0, '0},
      '{REQ_CREATE,   8'd1,   32'd0,          1'b0, '0},
      '{REQ_CREATE,   8'd1,   32'd0,          1'b0, '0},
      '{REQ_SCHEDULE, 8'd0,   32'd0,          1'b0, '0},
      '{REQ_DELAY,    8'd0,   32'hFFFF_FFFF,  1'b0, '0},
      '{REQ_DELAY,    8'd0,   32'd2,          1'b0, '0},
      '{REQ_TICK,     8'd0,   32'd0,          1'b0, '0},
      '{REQ_TICK,     8'd0,   32'd0,          1'b0, '0},
      '{REQ_DELAY,    8'd0,   32'd0,          1'b0, '0},
      '{REQ_TICK,     8'd0,   32'd0,          1'b0, '0},
      '{REQ_CREATE,   8'd128, 32'd0,          1'b0, '0},
      '{REQ_CREATE,   8'd2,   32'd0,          1'b0, '0},
      '{REQ_CREATE,   8'd3,   32'd0,          1'b0, '0},
      '{REQ_CREATE,   8'd4,   32'd0,          1'b0, '0},
      '{REQ_CREATE,   8'd0,   32'd0,          1'b1, '{STAT_FULL,    3'd3, 32'd4}},
      '{REQ_CREATE,   8'd7,   32'd0,          1'b1, '{STAT_FULL,    3'd3, 32'd4}},
      '{REQ_DELAY,    8'd0,   32'h8000_0010,  1'b0, '0},
      '{REQ_TICK,     8'd0,   32'd0,          1'b0, '0},
      '{REQ_SCHEDULE, 8'd0,   32'd0,          1'b0, '0}
    };
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      drive_request(directed_rows[r].kind, directed_rows[r].pri, directed_rows[r].dly,
                    directed_rows[r].typed, directed_rows[r].outcome);
    end
    drain_outcomes();

    for (int n = 0; n < RandomRequests; n++) begin
      pick = $urandom_range(0, 99);
      pri = PriW'($urandom);
      dly = $urandom;
      if (pick < 6) begin
        kind = REQ_CREATE;
      end else if (pick < 40) begin
        kind = REQ_DELAY;
        pick = $urandom_range(0, 99);
        if (pick < 70) dly = $urandom_range(0, 15);
        else if (pick < 90) dly = $urandom_range(16, 300);
        else dly = {24'hFF_FFFF, 8'($urandom)};
      end else if (pick < 75) begin
        kind = REQ_TICK;
      end else begin
        kind = REQ_SCHEDULE;
      end
      drive_request(kind, pri, dly, 1'b0, '0);
      if (n % 400 == 399) drain_outcomes();
    end

    drain_outcomes();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
